FILE: src/pmd_pkg.sv
`default_nettype none
package pmd_pkg;

  localparam int unsigned TabLen = 66;

  typedef logic [15:0] sample_t;
  typedef logic [16:0] thr_t;
  typedef logic signed [6:0] db_t;

  // Thresholds rise strictly; the last one lies above every 16-bit peak.
  localparam thr_t THR_TAB [TabLen] = '{
    17'd992,   17'd1985,  17'd2978,  17'd3971,  17'd4964,  17'd5957,  17'd6950,
    17'd7943,  17'd8936,  17'd9929,  17'd10922, 17'd11915, 17'd12908, 17'd13901,
    17'd14894, 17'd15887, 17'd16880, 17'd17873, 17'd18866, 17'd19859, 17'd20852,
    17'd21845, 17'd22838, 17'd23831, 17'd24824, 17'd25817, 17'd26810, 17'd27803,
    17'd28796, 17'd29789, 17'd30782, 17'd31775, 17'd32768, 17'd33760, 17'd34753,
    17'd35746, 17'd36739, 17'd37732, 17'd38725, 17'd39718, 17'd40711, 17'd41704,
    17'd42697, 17'd43690, 17'd44683, 17'd45676, 17'd46669, 17'd47662, 17'd48655,
    17'd49648, 17'd50641, 17'd51634, 17'd52627, 17'd53620, 17'd54613, 17'd55606,
    17'd56599, 17'd57592, 17'd58585, 17'd59578, 17'd60571, 17'd61564, 17'd62557,
    17'd63550, 17'd64543, 17'd65536
  };

  localparam db_t DB_TAB [TabLen] = '{
    -7'sd36, -7'sd30, -7'sd26, -7'sd24, -7'sd22, -7'sd20, -7'sd19, -7'sd18,
    -7'sd17, -7'sd16, -7'sd15, -7'sd14, -7'sd14, -7'sd13, -7'sd12, -7'sd12,
    -7'sd11, -7'sd11, -7'sd10, -7'sd10, -7'sd9,  -7'sd9,  -7'sd9,  -7'sd8,
    -7'sd8,  -7'sd8,  -7'sd7,  -7'sd7,  -7'sd7,  -7'sd6,  -7'sd6,  -7'sd6,
    -7'sd6,  -7'sd5,  -7'sd5,  -7'sd5,  -7'sd5,  -7'sd4,  -7'sd4,  -7'sd4,
    -7'sd4,  -7'sd3,  -7'sd3,  -7'sd3,  -7'sd3,  -7'sd3,  -7'sd2,  -7'sd2,
    -7'sd2,  -7'sd2,  -7'sd2,  -7'sd2,  -7'sd1,  -7'sd1,  -7'sd1,  -7'sd1,
    -7'sd1,  -7'sd1,  7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,
    7'sd0,   7'sd0
  };

  localparam sample_t DECAY_GAIN_RST = 16'd58982;

  // dB value of the first entry whose threshold lies above the peak.
  // All compares are against constants and run side by side.
  function automatic db_t level_of(input sample_t peak);
    db_t db;
    db = 7'sd0;
    for (int i = TabLen - 1; i >= 0; i--) begin
      if ({1'b0, peak} < THR_TAB[i]) begin
        db = DB_TAB[i];
      end
    end
    return db;
  endfunction

endpackage
`default_nettype wire

FILE: src/peak_meter_decay_dbfs_unit.sv
`default_nettype none
// Peak level meter: takes one ADC sample per cycle unless stalled, tracks
// the maximum of each buffer, and on the sample marked last updates the
// held peak (new maximum if larger, else peak * decay_gain / 65536,
// truncated) and emits one beat with the peak, its dBFS level and an
// undefined flag for a zero peak. Samples are taken back to back at one
// per cycle while in_stall is low. A result passes the input register, the
// peak update stage (one 16x16 multiply) and the table lookup into the
// output register. A stalled result does not hold up input until both
// internal stages are full. Write decay_gain only while the block is idle.
module peak_meter_decay_dbfs_unit
  import pmd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [15:0]       sample,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [15:0]            peak_level,
  output logic signed [6:0]      level_dbfs,
  output logic                   level_undefined
);

  sample_t decay_gain;
  sample_t buffer_max;
  sample_t peak_hold;
  sample_t peak_hold_next;

  logic    r_valid;
  sample_t r_sample;
  logic    r_last;

  logic    mid_valid;
  sample_t mid_peak;

  sample_t     m;
  logic [31:0] prod;
  logic        ready_out;
  logic        ready_mid;
  logic        adv_r;
  logic        adv_mid;
  logic        in_acc;

  assign ready_out = !out_valid || !out_stall;
  assign ready_mid = !mid_valid || ready_out;
  // Samples without the last mark retire on their own; only a last one
  // needs room downstream.
  assign adv_r     = r_valid && (!r_last || ready_mid);
  assign adv_mid   = mid_valid && ready_out;
  assign in_stall  = r_valid && !adv_r;
  assign in_acc    = in_valid && !in_stall;

  assign m    = (r_sample > buffer_max) ? r_sample : buffer_max;
  assign prod = peak_hold * decay_gain;

  always_comb begin
    if (peak_hold < m) begin
      peak_hold_next = m;
    end else begin
      peak_hold_next = prod[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_gain <= DECAY_GAIN_RST;
    end else if (cfg_wen) begin
      decay_gain <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_acc) begin
      r_valid <= 1'b1;
    end else if (adv_r) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      r_sample <= sample;
      r_last   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_max <= '0;
      peak_hold  <= '0;
    end else if (adv_r) begin
      if (r_last) begin
        buffer_max <= '0;
        peak_hold  <= peak_hold_next;
      end else begin
        buffer_max <= m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (adv_r && r_last) begin
      mid_valid <= 1'b1;
    end else if (adv_mid) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_r && r_last) begin
      mid_peak <= peak_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_mid) begin
      out_valid <= 1'b1;
    end else if (ready_out) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_mid) begin
      peak_level      <= mid_peak;
      level_undefined <= (mid_peak == '0);
      level_dbfs      <= (mid_peak == '0) ? 7'sd0 : level_of(mid_peak);
    end
  end

`ifndef SYNTHESIS
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_undefined == (peak_level == 16'd0)))
    else $error("undefined flag does not match a zero peak");

  a_db_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_dbfs <= 7'sd0 && level_dbfs >= -7'sd36))
    else $error("dBFS level out of range");

  a_max_clear: assert property (@(posedge clk) disable iff (rst)
    (adv_r && r_last) |=> (buffer_max == 16'd0))
    else $error("buffer maximum not cleared at end of buffer");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (r_valid && r_last && mid_valid))
    else $error("input stalled while the pipeline has room");
`endif

endmodule
`default_nettype wire

FILE: sim/peak_meter_decay_dbfs_unit_tb.sv
`default_nettype none
module peak_meter_decay_dbfs_unit_tb;
  import pmd_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_CAP = 40;
  localparam int LEVEL_STEPS = 66;

  // Level steps: a peak reads the dB value of the first threshold above it.
  localparam int STEP_THR [LEVEL_STEPS] = '{
    992, 1985, 2978, 3971, 4964, 5957, 6950, 7943, 8936, 9929,
    10922, 11915, 12908, 13901, 14894, 15887, 16880, 17873, 18866,
    19859, 20852, 21845, 22838, 23831, 24824, 25817, 26810, 27803,
    28796, 29789, 30782, 31775, 32768, 33760, 34753, 35746, 36739,
    37732, 38725, 39718, 40711, 41704, 42697, 43690, 44683, 45676,
    46669, 47662, 48655, 49648, 50641, 51634, 52627, 53620, 54613,
    55606, 56599, 57592, 58585, 59578, 60571, 61564, 62557, 63550,
    64543, 65536
  };
  localparam int STEP_DB [LEVEL_STEPS] = '{
    -36, -30, -26, -24, -22, -20, -19, -18, -17, -16, -15, -14, -14, -13,
    -12, -12, -11, -11, -10, -10, -9, -9, -9, -8, -8, -8, -7, -7, -7, -6,
    -6, -6, -6, -5, -5, -5, -5, -4, -4, -4, -4, -3, -3, -3, -3, -3, -2, -2,
    -2, -2, -2, -2, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    sample_t peak;
    db_t     db;
    logic    undef;
  } meter_read_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wen;
  logic [15:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [15:0] sample;
  logic last;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] peak_level;
  logic signed [6:0] level_dbfs;
  logic level_undefined;

  // Meter state as the testbench sees it.
  sample_t gain_q;
  sample_t run_max;
  sample_t held_peak;
  meter_read_t pending_reads[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic out_hold = 1'b0;
  event hold_go;

  int errors = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int gains_used = 0;
  int cycle_cnt = 0;

  peak_meter_decay_dbfs_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .last            (last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .peak_level      (peak_level),
    .level_dbfs      (level_dbfs),
    .level_undefined (level_undefined)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** peak_meter_decay_dbfs_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= out_hold || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off, started by the backpressure test.
  always begin
    @(hold_go);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  function automatic db_t db_for_peak(input sample_t peak);
    for (int i = 0; i < LEVEL_STEPS; i++) begin
      if (peak < STEP_THR[i]) begin
        return db_t'(STEP_DB[i]);
      end
    end
    return db_t'(0);
  endfunction

  task automatic update_meter(input sample_t s, input logic is_last);
    sample_t m;
    meter_read_t r;
    logic [31:0] prod;
    m = (s > run_max) ? s : run_max;
    if (!is_last) begin
      run_max = m;
    end else begin
      // A buffer maximum equal to the held peak still decays the peak.
      if (held_peak < m) begin
        held_peak = m;
      end else begin
        prod = held_peak * gain_q;
        held_peak = prod[31:16];
      end
      run_max = '0;
      r.peak = held_peak;
      r.undef = (held_peak == 0);
      r.db = r.undef ? db_t'(0) : db_for_peak(held_peak);
      pending_reads.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < REPORT_CAP) begin
      $display("[%0d] mismatch: %s got %0d want %0d", cycle_cnt, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    meter_read_t want;
    if (!rst) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid unknown", 0, 0);
      end else if (out_valid && !out_stall) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("result beat with none pending, peak", peak_level, 0);
        end else begin
          want = pending_reads.pop_front();
          beats_checked++;
          if (peak_level !== want.peak) begin
            report_mismatch("peak_level", peak_level, want.peak);
          end
          if (level_dbfs !== want.db) begin
            report_mismatch("level_dbfs", int'(level_dbfs), int'($signed(want.db)));
          end
          if (level_undefined !== want.undef) begin
            report_mismatch("level_undefined", level_undefined, want.undef);
          end
        end
      end
    end
  end

  // Offers one beat and returns at the edge that accepts it.
  task automatic send_beat(input sample_t s, input logic is_last);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    last <= is_last;
    do @(posedge clk); while (in_stall);
    update_meter(s, is_last);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input sample_t g);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_wen <= 1'b0;
    gain_q = g;
    gains_used++;
  endtask

  function automatic sample_t rand_sample();
    int idx;
    case ($urandom_range(6))
      0, 1: return sample_t'($urandom_range(65535));
      2: return sample_t'($urandom_range(1023));
      3: return sample_t'(65535 - $urandom_range(15));
      4: begin
        if (held_peak == 0) return sample_t'($urandom_range(2));
        if (held_peak == 16'hFFFF) return sample_t'(65535 - $urandom_range(1));
        return sample_t'(held_peak + $urandom_range(2) - 1);
      end
      5: begin
        idx = $urandom_range(LEVEL_STEPS - 2);
        return sample_t'(STEP_THR[idx] - $urandom_range(1));
      end
      default: return '0;
    endcase
  endfunction

  task automatic send_buffer(input int len);
    for (int i = 0; i < len; i++) begin
      send_beat(rand_sample(), i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_beat(16'd0, 1'b1);
    send_beat(16'd100, 1'b0);
    send_beat(16'd50, 1'b1);
    send_beat(16'hFFFF, 1'b1);
    send_beat(16'd1000, 1'b1);
    send_beat(held_peak, 1'b1);
    send_beat(16'd5, 1'b0);
    send_beat(16'd60000, 1'b0);
    send_beat(16'd7, 1'b0);
    send_beat(16'd3, 1'b1);
    send_beat(16'd0, 1'b0);
    send_beat(16'd0, 1'b0);
    send_beat(16'hFFFF, 1'b1);
  endtask

  // With zero gain every non-rising buffer clears the peak, so an ascending
  // list sets each peak exactly to its value, on either side of a level boundary.
  task automatic test_level_edges();
    sample_t edges [8] = '{16'd1, 16'd991, 16'd992, 16'd32767, 16'd32768,
                           16'd64542, 16'd64543, 16'd65535};
    write_gain(16'd0);
    send_beat(16'd0, 1'b1);
    foreach (edges[i]) send_beat(edges[i], 1'b1);
    send_beat(16'd10, 1'b1);
  endtask

  task automatic test_random(input sample_t g, input int idle_pct, input int stall,
                             input int n_items);
    int start;
    int len;
    write_gain(g);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      send_buffer(len);
    end
  endtask

  task automatic test_backpressure();
    write_gain(DECAY_GAIN_RST);
    send_idle_pct = 0;
    stall_pct = 0;
    -> hold_go;
    for (int i = 0; i < 60; i++) begin
      send_beat(rand_sample(), $urandom_range(3) != 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    sample = '0;
    last = 1'b0;
    gain_q = DECAY_GAIN_RST;
    run_max = '0;
    held_peak = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_level_edges();
    test_random(16'hFFFF, 0, 0, 130);
    test_random(16'd1, 67, 0, 130);
    test_random(sample_t'($urandom_range(65535)), 0, 67, 130);
    test_random(16'd32768, 31, 31, 130);
    test_backpressure();
    wait_idle();

    $display("Sent %0d sample beats and checked %0d meter readings over %0d gain settings,",
             items_sent, beats_checked, gains_used);
    $display("including zero and full gain, level boundaries and a long output hold-off.");
    if (errors == 0) begin
      $display("** peak_meter_decay_dbfs_unit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** peak_meter_decay_dbfs_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
